// ===== src/tcm_pkg.sv =====
// Package for the tempo clock multiplier: register indexes and the result word type.
// No dependencies.
package tcm_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_PRESCALE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_WRAP     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_PRESCALE     = 8'd3;

  localparam logic [15:0] CAPTURE_PRESCALE_RST = 16'd1;
  localparam logic [31:0] CAPTURE_WRAP_RST     = 32'd65535;
  localparam logic [15:0] SUB_PRESCALE_RST     = 16'd1;
  localparam logic [15:0] RELOAD_MAX           = 16'hFFFF;

  typedef struct packed {
    logic        pulse_fire;
    logic [7:0]  pulse_index;
    logic        beat_start;
    logic        capture_event;
    logic [31:0] captured_period;
  } res_t;

endpackage

// ===== src/tempo_clock_multiplier.sv =====
// Top level of the tempo clock multiplier: counters, capture and output buffering.
// Depends on tcm_pkg.
//
// Usage
//   Input channel (in_valid / in_stall / in_tempo_edge): one word per base-clock
//   tick; in_tempo_edge marks a falling edge of the external tempo clock.
//   Result channel (out_valid / out_stall / out_*): exactly one result word per
//   input word, in order.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, index 0 run_enable, 1 capture_prescale, 2 capture_wrap,
//   3 sub_prescale; other indexes are dropped. cfg_ready is always high.
//   Output: each result word is registered into the output register, or into
//   the skid register while the output is held. Throughput: one word per cycle
//   while in_stall is low; all counter updates happen in the accept cycle.
//   Stall: an output register plus a one-word skid register. in_stall rises
//   only when both hold words, so a stalled receiver costs at most one extra
//   word before the input side is held off.
//   Reset (rst_n low, synchronous): counters, position and captured period
//   clear, registers take their reset values, both buffers empty.
//   The period / PULSES_PER_BEAT quotient is tracked incrementally alongside
//   the period counter (remainder counter plus saturating quotient), so no
//   divider is needed at capture time.
module tempo_clock_multiplier
  import tcm_pkg::*;
#(
  parameter int unsigned PULSES_PER_BEAT = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_tempo_edge,
  // result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_pulse_fire,
  output logic [7:0]           out_pulse_index,
  output logic                 out_beat_start,
  output logic                 out_capture_event,
  output logic [31:0]          out_captured_period,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int unsigned REM_W = $clog2(PULSES_PER_BEAT);
  localparam logic [REM_W-1:0] REM_LAST = REM_W'(PULSES_PER_BEAT - 1);
  localparam logic [7:0]       POS_LAST = 8'(PULSES_PER_BEAT - 1);

  // configuration registers
  logic        run_enable_r;
  logic [15:0] capture_prescale_r;
  logic [31:0] capture_wrap_r;
  logic [15:0] sub_prescale_r;

  // counter state
  logic [15:0]      cap_pre_cnt_r, cap_pre_cnt_nxt;
  logic [31:0]      period_cnt_r, period_cnt_nxt;
  logic [REM_W-1:0] period_rem_r, period_rem_nxt;   // period_cnt mod beat length
  logic [15:0]      period_quot_r, period_quot_nxt; // period_cnt / beat length, saturated
  logic [15:0]      sub_pre_cnt_r, sub_pre_cnt_nxt;
  logic [15:0]      sub_cnt_r, sub_cnt_nxt;
  logic [15:0]      sub_reload_r, sub_reload_nxt;
  logic [7:0]       pulse_pos_r, pulse_pos_nxt;
  logic [31:0]      last_period_r, last_period_nxt;

  // output buffering
  res_t res;
  res_t out_r, skid_r;
  logic out_valid_r, skid_valid_r;
  logic in_take, out_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_take   = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_enable_r       <= 1'b0;
      capture_prescale_r <= CAPTURE_PRESCALE_RST;
      capture_wrap_r     <= CAPTURE_WRAP_RST;
      sub_prescale_r     <= SUB_PRESCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RUN_ENABLE:       run_enable_r       <= cfg_data[0];
        CFG_CAPTURE_PRESCALE: capture_prescale_r <= cfg_data[15:0];
        CFG_CAPTURE_WRAP:     capture_wrap_r     <= cfg_data;
        CFG_SUB_PRESCALE:     sub_prescale_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // one tick of the counters
  always_comb begin
    cap_pre_cnt_nxt = cap_pre_cnt_r;
    period_cnt_nxt  = period_cnt_r;
    period_rem_nxt  = period_rem_r;
    period_quot_nxt = period_quot_r;
    sub_pre_cnt_nxt = sub_pre_cnt_r;
    sub_cnt_nxt     = sub_cnt_r;
    sub_reload_nxt  = sub_reload_r;
    pulse_pos_nxt   = pulse_pos_r;
    last_period_nxt = last_period_r;
    res             = '0;

    if (run_enable_r) begin
      if (in_tempo_edge) begin
        // capture: latch period, load reload, restart everything, pulse 0
        last_period_nxt   = period_cnt_r;
        sub_reload_nxt    = period_quot_r;
        cap_pre_cnt_nxt   = '0;
        period_cnt_nxt    = '0;
        period_rem_nxt    = '0;
        period_quot_nxt   = '0;
        sub_pre_cnt_nxt   = '0;
        sub_cnt_nxt       = '0;
        pulse_pos_nxt     = (POS_LAST == 8'd0) ? 8'd0 : 8'd1;
        res.pulse_fire    = 1'b1;
        res.beat_start    = 1'b1;
        res.capture_event = 1'b1;
      end else begin
        // period counter
        if (cap_pre_cnt_r >= capture_prescale_r) begin
          cap_pre_cnt_nxt = '0;
          if (period_cnt_r >= capture_wrap_r) begin
            period_cnt_nxt  = '0;
            period_rem_nxt  = '0;
            period_quot_nxt = '0;
          end else begin
            period_cnt_nxt = period_cnt_r + 32'd1;
            if (period_rem_r == REM_LAST) begin
              period_rem_nxt = '0;
              if (period_quot_r != RELOAD_MAX) period_quot_nxt = period_quot_r + 16'd1;
            end else begin
              period_rem_nxt = period_rem_r + REM_W'(1);
            end
          end
        end else begin
          cap_pre_cnt_nxt = cap_pre_cnt_r + 16'd1;
        end
        // sub-counter; a zero reload holds it
        if (sub_pre_cnt_r >= sub_prescale_r) begin
          sub_pre_cnt_nxt = '0;
          if (sub_reload_r != 16'd0) begin
            if (sub_cnt_r >= sub_reload_r) begin
              sub_cnt_nxt     = '0;
              res.pulse_fire  = 1'b1;
              res.pulse_index = pulse_pos_r;
              res.beat_start  = (pulse_pos_r == 8'd0);
              pulse_pos_nxt   = (pulse_pos_r >= POS_LAST) ? 8'd0 : pulse_pos_r + 8'd1;
            end else begin
              sub_cnt_nxt = sub_cnt_r + 16'd1;
            end
          end
        end else begin
          sub_pre_cnt_nxt = sub_pre_cnt_r + 16'd1;
        end
      end
    end
    res.captured_period = last_period_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_pre_cnt_r <= '0;
      period_cnt_r  <= '0;
      period_rem_r  <= '0;
      period_quot_r <= '0;
      sub_pre_cnt_r <= '0;
      sub_cnt_r     <= '0;
      sub_reload_r  <= '0;
      pulse_pos_r   <= '0;
      last_period_r <= '0;
    end else if (in_take) begin
      cap_pre_cnt_r <= cap_pre_cnt_nxt;
      period_cnt_r  <= period_cnt_nxt;
      period_rem_r  <= period_rem_nxt;
      period_quot_r <= period_quot_nxt;
      sub_pre_cnt_r <= sub_pre_cnt_nxt;
      sub_cnt_r     <= sub_cnt_nxt;
      sub_reload_r  <= sub_reload_nxt;
      pulse_pos_r   <= pulse_pos_nxt;
      last_period_r <= last_period_nxt;
    end
  end

  // output register + skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_take;
      end
    end else if (in_take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_take) begin
      skid_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pulse_fire      = out_r.pulse_fire;
  assign out_pulse_index     = out_r.pulse_index;
  assign out_beat_start      = out_r.beat_start;
  assign out_capture_event   = out_r.capture_event;
  assign out_captured_period = out_r.captured_period;

  // checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a word while output register is empty");

  a_sub_within_reload: assert property (@(posedge clk) disable iff (!rst_n)
    sub_cnt_r <= sub_reload_r)
    else $error("sub-counter beyond reload");

  a_pos_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_pos_r <= POS_LAST)
    else $error("pulse position beyond beat length");

  a_rem_in_beat: assert property (@(posedge clk) disable iff (!rst_n)
    period_rem_r <= REM_LAST)
    else $error("period remainder out of range");

  a_beat_has_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.beat_start) |-> (out_r.pulse_fire && out_r.pulse_index == 8'd0))
    else $error("beat start without pulse zero");

endmodule

// ===== bench/tb_tempo_clock_multiplier.sv =====
// Self-checking bench for tempo_clock_multiplier: tick words in, one result word out per tick.
// Depends on tcm_pkg and the tempo_clock_multiplier RTL; a scoreboard class tracks the counters.
`timescale 1ns / 1ps

module tb_tempo_clock_multiplier;
  import tcm_pkg::*;

  localparam int BEAT_LEN = 24;
  localparam int RANDOM_ITEMS = 1000;
  // The limit must cover a run with every gap and stall at its longest; leave a
  // wide margin.
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int TAIL_CYCLES = 8;
  localparam int REPORT_CAP = 40;
  localparam int LONG_HOLD = 400;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;

  // Tracks the multiplier's counters and keeps the result words still owed.
  class pulse_scoreboard;
    bit        run_on;
    bit [15:0] period_div;
    bit [31:0] period_wrap;
    bit [15:0] sub_div;

    bit [15:0] period_div_cnt;
    bit [31:0] period_cnt;
    bit [15:0] sub_div_cnt;
    bit [15:0] sub_cnt;
    bit [15:0] sub_reload;
    bit [7:0]  position;
    bit [31:0] latched_period;

    res_t pulses_due[$];
    int   errors;

    function new();
      run_on         = 1'b0;
      period_div     = CAPTURE_PRESCALE_RST;
      period_wrap    = CAPTURE_WRAP_RST;
      sub_div        = SUB_PRESCALE_RST;
      period_div_cnt = '0;
      period_cnt     = '0;
      sub_div_cnt    = '0;
      sub_cnt        = '0;
      sub_reload     = '0;
      position       = '0;
      latched_period = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_RUN_ENABLE:       run_on = val[0];
        CFG_CAPTURE_PRESCALE: period_div = val[15:0];
        CFG_CAPTURE_WRAP:     period_wrap = val;
        CFG_SUB_PRESCALE:     sub_div = val[15:0];
        default: ;
      endcase
    endfunction

    function bit [7:0] take_index();
      bit [7:0] idx;
      idx = position;
      position = (position >= BEAT_LEN - 1) ? 8'd0 : position + 8'd1;
      return idx;
    endfunction

    // One accepted tick: advance the counters and queue the word it produces.
    function void note_tick(bit tempo_edge);
      res_t      want;
      bit [31:0] quot;
      want = '0;
      if (run_on) begin
        if (tempo_edge) begin
          latched_period = period_cnt;
          quot = period_cnt / BEAT_LEN;
          sub_reload = (quot > {16'd0, RELOAD_MAX}) ? RELOAD_MAX : quot[15:0];
          period_div_cnt = '0;
          period_cnt     = '0;
          sub_div_cnt    = '0;
          sub_cnt        = '0;
          position       = '0;
          want.pulse_index   = take_index();
          want.pulse_fire    = 1'b1;
          want.beat_start    = 1'b1;
          want.capture_event = 1'b1;
        end else begin
          if (period_div_cnt >= period_div) begin
            period_div_cnt = '0;
            period_cnt = (period_cnt >= period_wrap) ? 32'd0 : period_cnt + 32'd1;
          end else begin
            period_div_cnt++;
          end
          if (sub_div_cnt >= sub_div) begin
            sub_div_cnt = '0;
            if (sub_reload != 0) begin
              if (sub_cnt >= sub_reload) begin
                sub_cnt = '0;
                want.pulse_index = take_index();
                want.pulse_fire  = 1'b1;
                want.beat_start  = (want.pulse_index == 0);
              end else begin
                sub_cnt++;
              end
            end
          end else begin
            sub_div_cnt++;
          end
        end
      end
      want.captured_period = latched_period;
      pulses_due.push_back(want);
    endfunction

    function void compare_field(string field_name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s expected %h, actual %h", $time, field_name, want, got);
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      if (pulses_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result word expected none, actual %h", $time, got);
        return;
      end
      want = pulses_due.pop_front();
      compare_field("pulse_fire", 32'(want.pulse_fire), 32'(got.pulse_fire));
      compare_field("pulse_index", 32'(want.pulse_index), 32'(got.pulse_index));
      compare_field("beat_start", 32'(want.beat_start), 32'(got.beat_start));
      compare_field("capture_event", 32'(want.capture_event), 32'(got.capture_event));
      compare_field("captured_period", want.captured_period, got.captured_period);
    endfunction

    function int pending();
      return pulses_due.size();
    endfunction
  endclass

  // All block inputs start at known values.
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_tempo_edge = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_pulse_fire;
  logic [7:0]           out_pulse_index;
  logic                 out_beat_start;
  logic                 out_capture_event;
  logic [31:0]          out_captured_period;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  pulse_scoreboard sb = new();

  // Idle control shared with the driver and receiver processes.
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_burst_left = 0;
  int unsigned cycle_cnt = 0;

  tempo_clock_multiplier #(
    .PULSES_PER_BEAT(BEAT_LEN)
  ) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_tempo_edge       (in_tempo_edge),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pulse_fire      (out_pulse_fire),
    .out_pulse_index     (out_pulse_index),
    .out_beat_start      (out_beat_start),
    .out_capture_event   (out_capture_event),
    .out_captured_period (out_captured_period),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #6 clk = ~clk;

  // Watchdog: a hung handshake or a lost word ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tempo_clock_multiplier: mismatch");
      $finish;
    end
  end

  // Handshakes are sampled at the edge, so pre-edge values decide what was taken.
  // Results always belong to ticks taken at earlier edges, so order within the
  // block does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_word(res_t'({out_pulse_fire, out_pulse_index, out_beat_start,
                              out_capture_event, out_captured_period}));
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        sb.note_tick(in_tempo_edge);
    end
  end

  // Receiver: a long hold on request, otherwise random stall bursts while idling
  // is on.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      rx_hold_left = LONG_HOLD;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (rx_burst_left != 0) begin
      rx_burst_left--;
      out_stall <= 1'b1;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_burst_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one tick word, maybe after a random gap, and hold it until taken.
  task automatic send_tick(input bit tempo_edge);
    if (tx_idle_on && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      in_tempo_edge <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tempo_edge <= tempo_edge;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every owed result word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int          ph;
    int          random_items;
    int          sent;
    int          target;
    int          k;
    int          j;
    bit          run_bit;
    logic [15:0] cp;
    logic [15:0] sp;
    logic [31:0] cw;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Disabled after reset: edges are ignored, words are all zero.
    send_tick(1'b1);
    send_tick(1'b0);
    // A write to an unmapped index must change nothing.
    drain_results();
    write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
    send_tick(1'b1);

    // Zero wrap pins the period at 0, so the reload stays 0 and no pulses follow.
    drain_results();
    write_reg(CFG_RUN_ENABLE, {31'($urandom), 1'b1});
    write_reg(CFG_CAPTURE_PRESCALE, 32'h0);
    write_reg(CFG_SUB_PRESCALE, 32'h0);
    write_reg(CFG_CAPTURE_WRAP, 32'h0);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);

    // Smallest wrap: the period toggles 0/1.
    drain_results();
    write_reg(CFG_CAPTURE_WRAP, 32'h1);
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);

    // Random phases: mostly regular beats with random spacing, some noisy edge
    // bursts. Counters carry over between phases, so lowered limits get hit
    // while a count is above them.
    random_items = 0;
    ph = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain_results();
      // Last stretch of the run has no idling on either side.
      tx_idle_on = (random_items < RANDOM_ITEMS - 250) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (random_items < RANDOM_ITEMS - 250) && ($urandom_range(0, 3) != 0);

      run_bit = (ph != 4);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: cp = 16'd0;
        6, 7:             cp = 16'($urandom_range(1, 3));
        8:                cp = 16'hFFFF;
        default:          cp = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: sp = 16'd0;
        5, 6, 7:       sp = 16'($urandom_range(1, 2));
        8:             sp = 16'hFFFF;
        default:       sp = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: cw = 32'd65535;
        3, 4, 5: cw = 32'hFFFF_FFFF;
        6, 7:    cw = $urandom_range(20, 300);
        8:       cw = 32'd1;
        default: cw = $urandom;
      endcase
      if (ph == 0) begin
        cp = 16'd0;
        sp = 16'd0;
        cw = 32'd65535;
      end else if (ph == 1) begin
        cp = 16'hFFFF;
        sp = 16'hFFFF;
        cw = 32'hFFFF_FFFF;
      end
      write_reg(CFG_RUN_ENABLE, {31'($urandom), run_bit});
      write_reg(CFG_CAPTURE_PRESCALE, {16'($urandom), cp});
      write_reg(CFG_CAPTURE_WRAP, cw);
      write_reg(CFG_SUB_PRESCALE, {16'($urandom), sp});

      // Receiver holds off for a long stretch while ticks keep coming.
      if (ph == 2)
        hold_req = 1'b1;

      target = (ph == 4) ? 30 : 120;
      sent = 0;
      while (sent < target) begin
        if ($urandom_range(0, 5) == 0) begin
          k = $urandom_range(3, 16);
          for (j = 0; j < k; j++) send_tick($urandom_range(0, 3) == 0);
          sent += k;
        end else begin
          k = $urandom_range(24, 220);
          send_tick(1'b1);
          for (j = 0; j < k; j++) send_tick(1'b0);
          sent += k + 1;
        end
        // Sender pauses mid-phase until every owed word is back.
        if (ph == 3 && sent >= target / 2 && sent - k <= target / 2)
          drain_results();
      end
      if (run_bit)
        random_items += sent;
      ph++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tempo_clock_multiplier: match");
    end else begin
      $display("tempo_clock_multiplier: mismatch");
    end
    $finish;
  end

endmodule
